@@ rtl/core/bounded_lifo_stack_core_defines.svh @@
// Assertion macros for the bounded LIFO stack core.
// Used by the port checker; no other dependencies.
`ifndef BOUNDED_LIFO_STACK_CORE_DEFINES_SVH
`define BOUNDED_LIFO_STACK_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BLS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bls check failed");

// Next-cycle implication, disabled during reset.
`define BLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bls check failed");

`endif

@@ rtl/core/bls_pkg.sv @@
// Shared types and constants for the bounded LIFO stack core.
// No dependencies; compiled first.
`default_nettype none

package bls_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int CFG_W   = 9;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 8;
  localparam int FILL_W  = 9;

  localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(256);

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_CHANGE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_RANGE     = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch command, access store, update count
    logic finish;  // load response register
  } ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/bls_if.sv @@
// Request and response channel interfaces for the stack core.
// Depends on bls_pkg.
`default_nettype none

interface bls_req_if
  import bls_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic signed [DATA_W-1:0] data_in;
  logic [POS_W-1:0]         position;

  modport source (output valid, output cmd, output data_in, output position, input ready);
  modport sink   (input valid, input cmd, input data_in, input position, output ready);
endinterface

interface bls_rsp_if
  import bls_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [FILL_W-1:0]        fill_count;
  logic                     is_empty;
  logic                     is_full;
  logic [1:0]               error_code;

  modport source (output valid, output data_out, output fill_count, output is_empty,
                  output is_full, output error_code, input ready);
  modport sink   (input valid, input data_out, input fill_count, input is_empty,
                  input is_full, input error_code, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bounded_lifo_stack_core.sv @@
// Bounded LIFO stack core: top level joining controller and datapath.
// Depends on bls_pkg, bls_if, bls_ctrl and bls_datapath.
// Usage:
//   req  : one command per transfer (push, pop, peek or change at position).
//   rsp  : exactly one response per command, in order: data_out, fill_count,
//          is_empty, is_full and error_code.
//   cfg  : cfg_wr_en/cfg_wr_data write the stack size limit; write it only
//          while no command is in flight.
// Timing:
//   A command is taken in the idle state, the store is accessed at that edge,
//   the response register loads in the exec state and the response is offered
//   in the resp state. The registered read of the entry store is why the exec
//   state lies between idle and resp.
//   One command at a time: req.ready is low until the response transfers.
// Reset:
//   rst (synchronous) empties the stack, marks every entry as reading zero
//   through per-entry valid bits (no clearing pass) and sets the limit to 256.
// Backpressure:
//   While rsp.ready is low the response holds steady and no new command is
//   taken.
`default_nettype none

module bounded_lifo_stack_core
  import bls_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_W-1:0]  cfg_wr_data,
  bls_req_if.sink                req,
  bls_rsp_if.source              rsp
);

  ctrl_t ctrl;

  // sequencing: idle -> exec -> resp
  bls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctrl      (ctrl)
  );

  // store, count, limit and response register
  bls_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .req_cmd      (req.cmd),
    .req_data     (req.data_in),
    .req_position (req.position),
    .data_out     (rsp.data_out),
    .fill_count   (rsp.fill_count),
    .is_empty     (rsp.is_empty),
    .is_full      (rsp.is_full),
    .error_code   (rsp.error_code)
  );

endmodule

`default_nettype wire

@@ rtl/core/bls_ctrl.sv @@
// Sequencing state machine for the stack core.
// Depends on bls_pkg.
`default_nettype none

module bls_ctrl
  import bls_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output ctrl_t     ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;
    ctrl.accept = 1'b0;
    ctrl.finish = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctrl.accept = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl.finish = 1'b1;
        state_next  = ST_RESP;
      end
      ST_RESP: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/bls_datapath.sv @@
// Stack store, count, limit register and response register.
// Depends on bls_pkg; driven by bls_ctrl.
`default_nettype none

module bls_datapath
  import bls_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ctrl_t                    ctrl,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_W-1:0]         cfg_wr_data,
  input  wire logic [1:0]               req_cmd,
  input  wire logic signed [DATA_W-1:0] req_data,
  input  wire logic [POS_W-1:0]         req_position,
  output logic signed [DATA_W-1:0]      data_out,
  output logic [FILL_W-1:0]             fill_count,
  output logic                          is_empty,
  output logic                          is_full,
  output logic [1:0]                    error_code
);

  logic [CFG_W-1:0]  stack_limit;
  logic [CNT_W-1:0]  active_lim;
  logic [CNT_W-1:0]  top_count, top_count_next;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  entry_valid;
  logic [DATA_W-1:0] rd_data;
  logic              rd_valid;

  logic              mem_we, mem_re, valid_clr;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              pos_bad;
  err_t              err_next;
  err_t              err_q;
  logic              want_data_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      stack_limit <= cfg_wr_data;
    end
  end

  // zero acts as one, above DEPTH acts as DEPTH
  always_comb begin
    if (stack_limit == '0) begin
      active_lim = CNT_W'(1);
    end else if (32'(stack_limit) > DEPTH) begin
      active_lim = CNT_W'(DEPTH);
    end else begin
      active_lim = CNT_W'(stack_limit);
    end
  end

  assign pos_bad = (32'(req_position) >= 32'(active_lim));

  // decode of the incoming command
  always_comb begin
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    valid_clr      = 1'b0;
    wr_addr        = top_count[ADDR_W-1:0];
    rd_addr        = ADDR_W'(req_position);
    top_count_next = top_count;
    err_next       = ERR_OK;
    case (cmd_t'(req_cmd))
      CMD_PUSH: begin
        if (top_count >= active_lim) begin
          err_next = ERR_OVERFLOW;
        end else begin
          mem_we         = 1'b1;
          top_count_next = top_count + CNT_W'(1);
        end
      end
      CMD_POP: begin
        rd_addr = ADDR_W'(top_count - CNT_W'(1));
        if (top_count == '0) begin
          err_next = ERR_UNDERFLOW;
        end else begin
          mem_re         = 1'b1;
          valid_clr      = 1'b1;
          top_count_next = top_count - CNT_W'(1);
        end
      end
      CMD_PEEK: begin
        if (pos_bad) begin
          err_next = ERR_RANGE;
        end else begin
          mem_re = 1'b1;
        end
      end
      CMD_CHANGE: begin
        wr_addr = ADDR_W'(req_position);
        if (pos_bad) begin
          err_next = ERR_RANGE;
        end else begin
          mem_we = 1'b1;
        end
      end
      default: begin
        err_next = ERR_OK;
      end
    endcase
  end

  // store: one write, one registered read
  always_ff @(posedge clk) begin
    if (ctrl.accept && mem_we) begin
      mem[wr_addr] <= req_data;
    end
    if (ctrl.accept) begin
      rd_data <= mem[rd_addr];
    end
  end

  // entries never written, or vacated by a pop, read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else if (ctrl.accept) begin
      rd_valid <= entry_valid[rd_addr];
      if (mem_we) begin
        entry_valid[wr_addr] <= 1'b1;
      end else if (valid_clr) begin
        entry_valid[rd_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= '0;
    end else if (ctrl.accept) begin
      top_count <= top_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      err_q       <= err_next;
      want_data_q <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      data_out   <= (want_data_q && rd_valid) ? rd_data : '0;
      fill_count <= FILL_W'(top_count);
      is_empty   <= (top_count == '0);
      is_full    <= (top_count >= active_lim);
      error_code <= err_q;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bls_checker.sv @@
// Port-level checks for the bounded LIFO stack core, bound to the top level.
// Depends on bls_pkg and bounded_lifo_stack_core_defines.svh.
`default_nettype none

`include "bounded_lifo_stack_core_defines.svh"

module bls_checker
  import bls_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_ready,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic [DATA_W-1:0] data_out,
  input wire logic [FILL_W-1:0] fill_count,
  input wire logic              is_empty,
  input wire logic              is_full,
  input wire logic [1:0]        error_code
);

  `BLS_ASSERT_NOW(a_empty_flag, clk, rst, rsp_valid, is_empty == (fill_count == '0))
  `BLS_ASSERT_NOW(a_empty_not_full, clk, rst, rsp_valid && is_empty, !is_full)
  `BLS_ASSERT_NOW(a_err_zero_data, clk, rst, rsp_valid && (error_code != ERR_OK), data_out == '0)
  `BLS_ASSERT_NOW(a_one_in_flight, clk, rst, rsp_valid, !req_ready)
  `BLS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(data_out))

endmodule

bind bounded_lifo_stack_core bls_checker u_bls_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .data_out   (rsp.data_out),
  .fill_count (rsp.fill_count),
  .is_empty   (rsp.is_empty),
  .is_full    (rsp.is_full),
  .error_code (rsp.error_code)
);

`default_nettype wire
